@@ hdl/tmd_pkg.sv @@
`default_nettype none
package tmd_pkg;

    localparam int MAX_SIDE_LOG2 = 8;
    localparam int SIDE_W        = MAX_SIDE_LOG2;
    localparam int ADDR_W        = 2 * MAX_SIDE_LOG2;
    localparam int DEPTH         = 1 << ADDR_W;
    localparam int COORD_W       = MAX_SIDE_LOG2 - 1;
    localparam int PIX_W         = 32;
    localparam int CH_W          = 8;
    localparam int NUM_CH        = PIX_W / CH_W;
    localparam int ACC_W         = 14;
    localparam int LOG_W         = 4;
    localparam int CNT_W         = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = LOG_W;

    // stream tdata layout
    localparam int TD_WADDR_LSB  = 0;
    localparam int TD_PIX_LSB    = TD_WADDR_LSB + ADDR_W;
    localparam int TD_OC_LSB     = TD_PIX_LSB + PIX_W;
    localparam int TD_ORW_LSB    = TD_OC_LSB + COORD_W;
    localparam int TD_IN_W       = ((TD_ORW_LSB + COORD_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LOG2  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TENT_FILTER = 2'd2;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [1:0] MODE_LIN  = 2'd0;
    localparam logic [1:0] MODE_BOX  = 2'd1;
    localparam logic [1:0] MODE_TENT = 2'd2;

    localparam int DIV_MUL_W = 15;
    localparam int DIV_SHIFT = 20;
    localparam logic [DIV_MUL_W-1:0] DIV36_MUL = 15'd29128;

    typedef struct packed {
        logic       clear;
        logic       acc_en;
        logic [1:0] wsh;
        logic       fin;
        logic [1:0] mode;
    } t_acc_ctl;

    function automatic logic [CH_W-1:0] div36(input logic [ACC_W-1:0] x);
        logic [ACC_W+DIV_MUL_W-1:0] p;
        p = (ACC_W + DIV_MUL_W)'(x) * (ACC_W + DIV_MUL_W)'(DIV36_MUL);
        return CH_W'(p >> DIV_SHIFT);
    endfunction

endpackage
`default_nettype wire

@@ hdl/tmd_pixel_ram.sv @@
`default_nettype none
module tmd_pixel_ram (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [tmd_pkg::ADDR_W-1:0] i_waddr,
    input  wire logic [tmd_pkg::PIX_W-1:0]  i_wdata,
    input  wire logic                       i_re,
    input  wire logic [tmd_pkg::ADDR_W-1:0] i_raddr,
    output logic      [tmd_pkg::PIX_W-1:0]  o_rdata
);
    import tmd_pkg::*;

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ hdl/tmd_filter_acc.sv @@
`default_nettype none
module tmd_filter_acc (
    input  wire logic                      i_clk,
    input  wire tmd_pkg::t_acc_ctl         i_ctl,
    input  wire logic [tmd_pkg::PIX_W-1:0] i_pix,
    output logic      [tmd_pkg::PIX_W-1:0] o_result
);
    import tmd_pkg::*;

    logic [ACC_W-1:0] r_acc [NUM_CH];
    logic [ACC_W-1:0] n_acc [NUM_CH];
    logic [PIX_W-1:0] r_result;
    logic [PIX_W-1:0] n_result;

    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            if (i_ctl.clear) begin
                n_acc[k] = '0;
            end else if (i_ctl.acc_en) begin
                n_acc[k] = r_acc[k] + (ACC_W'(i_pix[k*CH_W +: CH_W]) << i_ctl.wsh);
            end else begin
                n_acc[k] = r_acc[k];
            end
        end
    end

    always_comb begin
        n_result = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            case (i_ctl.mode)
                MODE_LIN:  n_result[k*CH_W +: CH_W] = CH_W'(r_acc[k] >> 1);
                MODE_BOX:  n_result[k*CH_W +: CH_W] = CH_W'(r_acc[k] >> 2);
                MODE_TENT: n_result[k*CH_W +: CH_W] = div36(r_acc[k]);
                default:   n_result[k*CH_W +: CH_W] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_CH; k++) begin
            r_acc[k] <= n_acc[k];
        end
        if (i_ctl.fin) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule
`default_nettype wire

@@ hdl/texture_mip_downsample.sv @@
// Mip level generator for one power-of-two RGBA texture level.
// Input stream: tuser = opcode. A write transaction (opcode 0) stores pixel_rgba
// at write_address in the pixel memory and produces no result.
// A compute transaction (opcode 1) produces one result transaction on the
// output stream: tdata = result_rgba, tuser = out_of_range.
// Compute reads the source pixels one per cycle from the single memory read
// port, then drains the read, normalises the sums and loads the output
// register. It reads 16 source pixels in tent mode, 4 in box mode and 2 when
// one side is 1; the next input is taken only once the result has been loaded
// into the output register.
// An out-of-range request skips the reads and goes straight to the output register.
// Writes are taken back to back.
// Config writes (index 0 width_log2, 1 height_log2, 2 tent_filter) are always
// ready and take effect the next cycle; issue them only while idle.
// Reset restores width_log2 = 8, height_log2 = 8, tent mode and empties the
// output register; the pixel memory is not cleared.
// When the receiver stalls, the result waits in the output register; writes
// and the next compute's reads proceed, and that compute holds before
// loading its result until the register is free.
`default_nettype none
module texture_mip_downsample (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [tmd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tmd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: write_address[15:0], pixel_rgba[47:16], out_col[54:48],
    //        out_row[61:55], zero[63:62]
    input  wire logic [tmd_pkg::TD_IN_W-1:0]    s_axis_tdata,
    // tuser: opcode[0]
    input  wire logic                          s_axis_tuser,
    // output stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // tdata: result_rgba[31:0]
    output logic      [tmd_pkg::PIX_W-1:0]     m_axis_tdata,
    // tuser: out_of_range[0]
    output logic                               m_axis_tuser
);
    import tmd_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_READ    = 3'd1;
    localparam logic [2:0] ST_DRAIN   = 3'd2;
    localparam logic [2:0] ST_FIN     = 3'd3;
    localparam logic [2:0] ST_DELIVER = 3'd4;

    logic [LOG_W-1:0]   r_wl, r_hl;
    logic               r_tent;
    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, r_last;
    logic [1:0]         r_mode;
    logic [COORD_W-1:0] r_oc, r_orw;
    logic               r_bad;
    logic               r_rd_vld;
    logic [1:0]         r_wsh;
    logic               r_ovalid;
    logic [PIX_W-1:0]   r_odata;
    logic               r_ouser;

    logic               in_acc, cmp_acc, out_load;
    logic [ADDR_W-1:0]  in_waddr;
    logic [PIX_W-1:0]   in_pix;
    logic [COORD_W-1:0] in_oc, in_orw;
    logic [LOG_W-1:0]   wl_sat, hl_sat;
    logic [SIDE_W:0]    w_full, h_full;
    logic [SIDE_W-1:0]  ow, oh, wm, hm, n_lin, oc_ext, orw_ext;
    logic               one_by_one, lin, bad;
    logic [1:0]         sel_mode;
    logic [CNT_W-1:0]   sel_last;
    logic [1:0]         dx, dy;
    logic               off;
    logic [SIDE_W:0]    xs, ys;
    logic [SIDE_W-1:0]  x, y;
    logic [ADDR_W-1:0]  addr_2d, addr_lin, raddr;
    logic [1:0]         wsh;
    logic [PIX_W-1:0]   rdata, result;
    t_acc_ctl           acc_ctl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl   <= LOG_W'(MAX_SIDE_LOG2);
            r_hl   <= LOG_W'(MAX_SIDE_LOG2);
            r_tent <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH_LOG2:  r_wl   <= i_cfg_data;
                CFG_HEIGHT_LOG2: r_hl   <= i_cfg_data;
                CFG_TENT_FILTER: r_tent <= i_cfg_data[0];
                default:         r_tent <= r_tent;
            endcase
        end
    end

    assign in_waddr = s_axis_tdata[TD_WADDR_LSB +: ADDR_W];
    assign in_pix   = s_axis_tdata[TD_PIX_LSB +: PIX_W];
    assign in_oc    = s_axis_tdata[TD_OC_LSB +: COORD_W];
    assign in_orw   = s_axis_tdata[TD_ORW_LSB +: COORD_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cmp_acc       = in_acc && (s_axis_tuser == OP_COMPUTE);

    // level geometry
    assign wl_sat  = (r_wl > LOG_W'(MAX_SIDE_LOG2)) ? LOG_W'(MAX_SIDE_LOG2) : r_wl;
    assign hl_sat  = (r_hl > LOG_W'(MAX_SIDE_LOG2)) ? LOG_W'(MAX_SIDE_LOG2) : r_hl;
    assign w_full  = (SIDE_W+1)'(1) << wl_sat;
    assign h_full  = (SIDE_W+1)'(1) << hl_sat;
    assign ow      = SIDE_W'(w_full >> 1);
    assign oh      = SIDE_W'(h_full >> 1);
    assign wm      = SIDE_W'(w_full - (SIDE_W+1)'(1));
    assign hm      = SIDE_W'(h_full - (SIDE_W+1)'(1));
    assign n_lin   = ow | oh;
    assign oc_ext  = SIDE_W'(in_oc);
    assign orw_ext = SIDE_W'(in_orw);

    assign one_by_one = (wl_sat == '0) && (hl_sat == '0);
    assign lin        = (wl_sat == '0) || (hl_sat == '0);

    always_comb begin
        if (one_by_one) begin
            bad = 1'b1;
        end else if (lin) begin
            bad = (in_orw != '0) || (oc_ext >= n_lin);
        end else begin
            bad = (oc_ext >= ow) || (orw_ext >= oh);
        end
        if (lin) begin
            sel_mode = MODE_LIN;
            sel_last = CNT_W'(1);
        end else if (r_tent) begin
            sel_mode = MODE_TENT;
            sel_last = CNT_W'(15);
        end else begin
            sel_mode = MODE_BOX;
            sel_last = CNT_W'(3);
        end
    end

    // read address sequence
    always_comb begin
        if (r_mode == MODE_TENT) begin
            dx = r_cnt[1:0];
            dy = r_cnt[3:2];
        end else begin
            dx = {1'b0, r_cnt[0]};
            dy = {1'b0, r_cnt[1]};
        end
        off      = (r_mode == MODE_TENT);
        xs       = {1'b0, r_oc, 1'b0} + (SIDE_W+1)'(dx) - (SIDE_W+1)'(off);
        ys       = {1'b0, r_orw, 1'b0} + (SIDE_W+1)'(dy) - (SIDE_W+1)'(off);
        x        = xs[SIDE_W-1:0] & wm;
        y        = ys[SIDE_W-1:0] & hm;
        addr_2d  = (ADDR_W'(y) << wl_sat) | ADDR_W'(x);
        addr_lin = ADDR_W'({r_oc, r_cnt[0]});
        raddr    = (r_mode == MODE_LIN) ? addr_lin : addr_2d;
        if (r_mode == MODE_TENT) begin
            wsh = {1'b0, (dx == 2'd1) || (dx == 2'd2)}
                + {1'b0, (dy == 2'd1) || (dy == 2'd2)};
        end else begin
            wsh = 2'd0;
        end
    end

    assign out_load = (r_state == ST_DELIVER) && (!r_ovalid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (cmp_acc) begin
                    n_state = bad ? ST_DELIVER : ST_READ;
                end
            end
            ST_READ: begin
                if (r_cnt == r_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:   n_state = ST_FIN;
            ST_FIN:     n_state = ST_DELIVER;
            ST_DELIVER: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == ST_READ);
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wsh <= wsh;
        if (cmp_acc) begin
            r_bad  <= bad;
            r_mode <= sel_mode;
            r_last <= sel_last;
            r_oc   <= in_oc;
            r_orw  <= in_orw;
            r_cnt  <= '0;
        end else if (r_state == ST_READ) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (out_load) begin
            r_odata <= r_bad ? '0 : result;
            r_ouser <= r_bad;
        end
    end

    always_comb begin
        acc_ctl.clear  = cmp_acc;
        acc_ctl.acc_en = r_rd_vld;
        acc_ctl.wsh    = r_wsh;
        acc_ctl.fin    = (r_state == ST_FIN);
        acc_ctl.mode   = r_mode;
    end

    tmd_pixel_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && (s_axis_tuser == OP_WRITE)),
        .i_waddr (in_waddr),
        .i_wdata (in_pix),
        .i_re    (r_state == ST_READ),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    tmd_filter_acc u_filter (
        .i_clk    (i_clk),
        .i_ctl    (acc_ctl),
        .i_pix    (rdata),
        .o_result (result)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    a_load_from_deliver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_DELIVER))
        else $error("result loaded outside deliver state");

    a_read_data_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state == ST_READ))
        else $error("accumulate without a preceding read");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_cnt <= r_last))
        else $error("read counter beyond last tap");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("out-of-range result carries nonzero data");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> !$past(in_acc))
        else $error("input taken during reads");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

import tmd_pkg::*;

localparam int LIN_TAPS   = 2;
localparam int BOX_TAPS   = 4;
localparam int TENT_TAPS  = 16;
localparam int TENT_NORM  = 36;
localparam int MAX_REPORT = 10;

typedef struct packed {
    logic [PIX_W-1:0] rgba;
    logic             oor;
} t_mip_pixel;

class mip_level_model;
    bit [PIX_W-1:0]   texels [DEPTH];
    bit               loaded [DEPTH];
    logic [LOG_W-1:0] width_log2;
    logic [LOG_W-1:0] height_log2;
    bit               tent_mode;
    t_mip_pixel       awaited_pixels [$];
    int               errors;
    int               results;

    function new();
        width_log2  = LOG_W'(MAX_SIDE_LOG2);
        height_log2 = LOG_W'(MAX_SIDE_LOG2);
        tent_mode   = 1'b1;
        errors      = 0;
        results     = 0;
    endfunction

    function int side(logic [LOG_W-1:0] lg);
        return 1 << ((lg > MAX_SIDE_LOG2) ? MAX_SIDE_LOG2 : int'(lg));
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_WIDTH_LOG2:  width_log2  = val;
            CFG_HEIGHT_LOG2: height_log2 = val;
            CFG_TENT_FILTER: tent_mode   = val[0];
            default: ;
        endcase
    endfunction

    // List the source texels that one output pixel reads; return 1 when out of range.
    function bit footprint(input int oc, input int orw, ref int taps[$]);
        int w, h, ow, oh, base;
        taps.delete();
        w  = side(width_log2);
        h  = side(height_log2);
        ow = w >> 1;
        oh = h >> 1;
        if (w == 1 && h == 1)
            return 1'b1;
        if (ow == 0 || oh == 0) begin
            if (orw != 0 || oc >= ow + oh)
                return 1'b1;
            taps.push_back(2 * oc);
            taps.push_back(2 * oc + 1);
        end else if (oc >= ow || orw >= oh) begin
            return 1'b1;
        end else if (!tent_mode) begin
            base = 2 * orw * w + 2 * oc;
            taps.push_back(base);
            taps.push_back(base + 1);
            taps.push_back(base + w);
            taps.push_back(base + w + 1);
        end else begin
            for (int dy = 0; dy < 4; dy++)
                for (int dx = 0; dx < 4; dx++)
                    taps.push_back(((2 * orw + dy - 1) & (h - 1)) * w
                                   + ((2 * oc + dx - 1) & (w - 1)));
        end
        return 1'b0;
    endfunction

    function void take_request(logic op, int waddr, logic [PIX_W-1:0] pix, int oc, int orw);
        int taps[$];
        bit bad;
        int unsigned acc;
        int wt;
        logic [PIX_W-1:0] res;
        if (op == OP_WRITE) begin
            texels[waddr[ADDR_W-1:0]] = pix;
            loaded[waddr[ADDR_W-1:0]] = 1'b1;
            return;
        end
        bad = footprint(oc, orw, taps);
        res = '0;
        if (!bad) begin
            for (int k = 0; k < NUM_CH; k++) begin
                acc = 0;
                foreach (taps[i]) begin
                    wt = 1;
                    if (taps.size() == TENT_TAPS)
                        wt = ((i / 4 == 1 || i / 4 == 2) ? 2 : 1)
                           * ((i % 4 == 1 || i % 4 == 2) ? 2 : 1);
                    acc += wt * texels[taps[i]][CH_W*k +: CH_W];
                end
                case (taps.size())
                    LIN_TAPS: acc = acc >> 1;
                    BOX_TAPS: acc = acc >> 2;
                    default:  acc = acc / TENT_NORM;
                endcase
                res[CH_W*k +: CH_W] = acc[CH_W-1:0];
            end
        end
        awaited_pixels.push_back('{rgba: res, oor: bad});
    endfunction

    function void check_pixel(logic [PIX_W-1:0] rgba, logic oor);
        t_mip_pixel want;
        results++;
        if (awaited_pixels.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORT)
                $display("result %0d unexpected: rgba=%h oor=%b", results, rgba, oor);
            return;
        end
        want = awaited_pixels.pop_front();
        if (rgba !== want.rgba || oor !== want.oor) begin
            errors++;
            if (errors <= MAX_REPORT)
                $display("result %0d mismatch: rgba exp %h got %h, oor exp %b got %b",
                         results, want.rgba, rgba, want.oor, oor);
        end
    endfunction
endclass

module tb_top;

    localparam int RANDOM_ITEMS  = 1850;
    localparam int SETTLE_CYCLES = 24;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TD_IN_W-1:0]    s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [PIX_W-1:0]      m_axis_tdata;
    logic                  m_axis_tuser;

    mip_level_model texmod = new();
    bit             burst = 1'b0;
    int             accepted_items = 0;

    texture_mip_downsample dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [PIX_W-1:0] texel_value();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? '1 : '0;
        return $urandom;
    endfunction

    task automatic send(input logic op, input int waddr, input logic [PIX_W-1:0] pix,
                        input int oc, input int orw);
        logic [TD_IN_W-1:0] td;
        int gap;
        td = '0;
        td[TD_WADDR_LSB +: ADDR_W] = waddr[ADDR_W-1:0];
        td[TD_PIX_LSB +: PIX_W]    = pix;
        td[TD_OC_LSB +: COORD_W]   = oc[COORD_W-1:0];
        td[TD_ORW_LSB +: COORD_W]  = orw[COORD_W-1:0];
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= td;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        texmod.take_request(op, waddr, pix, oc, orw);
        accepted_items++;
    endtask

    task automatic store_texel(input int addr, input logic [PIX_W-1:0] pix);
        send(OP_WRITE, addr, pix, $urandom_range(0, 127), $urandom_range(0, 127));
    endtask

    // Load any texel the request would read that is not yet loaded, before issuing it.
    task automatic request(input int oc, input int orw);
        int taps[$];
        void'(texmod.footprint(oc, orw, taps));
        foreach (taps[i])
            if (!texmod.loaded[taps[i]])
                store_texel(taps[i], texel_value());
        send(OP_COMPUTE, $urandom_range(0, 65535), $urandom, oc, orw);
    endtask

    task automatic random_request();
        int w, h;
        w = texmod.side(texmod.width_log2);
        h = texmod.side(texmod.height_log2);
        if ($urandom_range(0, 6) == 0 || w * h == 1)
            request($urandom_range(0, 127), $urandom_range(0, 127));
        else if (w == 1 || h == 1)
            request($urandom_range(0, (w + h) / 2 - 1), 0);
        else
            request($urandom_range(0, w / 2 - 1), $urandom_range(0, h / 2 - 1));
    endtask

    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (texmod.awaited_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input int wl, input int hl, input bit tent);
        logic [CFG_IDX_W-1:0]  regs [3];
        logic [CFG_DATA_W-1:0] vals [3];
        quiesce();
        regs = '{CFG_WIDTH_LOG2, CFG_HEIGHT_LOG2, CFG_TENT_FILTER};
        vals = '{CFG_DATA_W'(wl), CFG_DATA_W'(hl),
                 {(CFG_DATA_W-1)'($urandom), tent}};
        for (int i = 0; i < 3; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            texmod.write_reg(regs[i], vals[i]);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            stall = burst ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            texmod.check_pixel(m_axis_tdata, m_axis_tuser);
        end
    end

    initial begin
        int wl, hl, n, r, w, h;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset level: 256x256 tent, wrap across both far edges
        request(127, 127);
        request(0, 0);

        configure(2, 2, 1'b0);
        store_texel(0, '1);
        store_texel(1, '1);
        store_texel(4, '1);
        store_texel(5, '1);
        request(0, 0);
        request(1, 1);
        request(2, 0);
        request(0, 2);

        configure(2, 2, 1'b1);
        request(1, 1);
        request(0, 0);

        configure(0, 0, 1'b1);
        request(0, 0);

        // one-dimensional level under tent
        configure(3, 0, 1'b1);
        request(3, 0);
        request(4, 0);
        request(0, 1);

        // oversized log2 saturates
        configure(0, 15, 1'b0);
        request(127, 0);
        configure(15, 15, 1'b0);
        request(127, 127);

        accepted_items = 0;
        while (accepted_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                wl = $urandom_range(0, 4);
                hl = $urandom_range(0, 4);
            end else if (r < 85) begin
                wl = $urandom_range(2, 6);
                hl = $urandom_range(0, 6);
            end else if (r < 93) begin
                wl = $urandom_range(5, 8);
                hl = $urandom_range(5, 8);
            end else begin
                wl = $urandom_range(7, 15);
                hl = $urandom_range(7, 15);
            end
            configure(wl, hl, $urandom_range(0, 1));
            burst = ($urandom_range(0, 3) == 0);
            w = texmod.side(texmod.width_log2);
            h = texmod.side(texmod.height_log2);
            if (w * h <= 256 && $urandom_range(0, 1) == 1)
                for (int a = 0; a < w * h; a++)
                    store_texel(a, texel_value());
            n = $urandom_range(20, 80);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    random_request();
                else if (r < 85)
                    store_texel($urandom_range(0, w * h - 1), texel_value());
                else
                    store_texel($urandom_range(0, 65535), texel_value());
            end
            burst = 1'b0;
        end

        quiesce();
        if (texmod.errors == 0 && texmod.awaited_pixels.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
